// ----- sv/event_history_ring_core_defines.svh -----
// Assertion macros used by the checker file.
`ifndef EVENT_HISTORY_RING_CORE_DEFINES_SVH
`define EVENT_HISTORY_RING_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define EHR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("event history ring: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define EHR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("event history ring: next-cycle check failed");

`endif

// ----- sv/ehr_pkg.sv -----
package ehr_pkg;

  localparam int DEPTH_DEF = 256;

  typedef enum logic [2:0] {
    FN_APPEND  = 3'd0,
    FN_CLEAR   = 3'd1,
    FN_PEEK    = 3'd2,
    FN_DEL_MAT = 3'd3,
    FN_DEL_AGE = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CK,
    ST_SH_RD,
    ST_SH_WR,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [31:0] stamp;
    logic [7:0]  target;
    logic [7:0]  origin;
    logic [7:0]  kind;
    logic [15:0] amount;
  } rec_t;

endpackage

// ----- sv/event_history_ring_core.sv -----
// Event history ring: DEPTH records of stamp, target, origin, kind, amount.
// Input channel (in_valid_i / in_stall_o) takes one operation per transfer:
// append, clear, peek by age, delete newest match, delete at age.
// Output channel (out_valid_o / out_stall_i) gives exactly one result per
// operation: ok flag, the record concerned and the fill count after it.
// Append, clear, unknown codes and out-of-range ages go straight to the
// result; peek reads one record. Delete newest match reads the records
// from the newest on, one at a time, and both deletes then move each newer
// record down one place in turn. Every step goes through the single
// memory read port and the one slot-address unit. One operation is in
// flight at a time; in_stall_o is high from transfer until its result is
// loaded into the output register.
// The output register holds a result under out_stall_i; a new operation
// may be taken meanwhile and waits at its end for the register to free.
// Reset empties the ring (fill 0, write pointer 0); record contents are
// not cleared and are never read before being written.
module event_history_ring_core #(
  parameter int DEPTH = ehr_pkg::DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic signed [7:0]  target_i,
  input  logic signed [7:0]  origin_i,
  input  logic [7:0]  kind_i,
  input  logic signed [15:0] amount_i,
  input  logic [31:0] stamp_i,
  input  logic [7:0]  age_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ok_o,
  output logic signed [7:0]  rec_target_o,
  output logic signed [7:0]  rec_origin_o,
  output logic [7:0]  rec_kind_o,
  output logic signed [15:0] rec_amount_o,
  output logic [31:0] rec_stamp_o,
  output logic [8:0]  fill_o
);
  import ehr_pkg::*;

  localparam int PW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;

  state_e state_q, state_d;
  func_e  op_q, op_d;
  logic [PW-1:0] wp_q, wp_d;
  logic [CW-1:0] held_q, held_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0] key_tgt_q, key_tgt_d, key_kind_q, key_kind_d;
  rec_t rec_q, rec_d;
  logic ok_q, ok_d;
  logic out_valid_q, out_valid_d;
  rec_t out_rec_q, out_rec_d;
  logic out_ok_q, out_ok_d;
  logic [8:0] out_fill_q, out_fill_d;

  logic in_xfer, out_free, age_bad, key_hit;
  logic [CW-1:0] slot_age;
  logic [PW-1:0] slot;
  logic mem_we;
  logic [PW-1:0] mem_waddr;
  rec_t mem_wdata, mem_rdata, new_rec;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign age_bad    = CMPW'(age_i) >= CMPW'(held_q);
  assign key_hit    = (mem_rdata.target == key_tgt_q) && (mem_rdata.kind == key_kind_q);
  assign slot_age   = (state_q == ST_SH_RD) ? (cnt_q - CW'(1)) : cnt_q;

  always_comb begin
    new_rec.stamp  = stamp_i;
    new_rec.target = target_i;
    new_rec.origin = origin_i;
    new_rec.kind   = kind_i;
    new_rec.amount = amount_i;
  end

  ehr_slot #(.DEPTH(DEPTH)) u_slot (
    .wp_i   (wp_q),
    .age_i  (slot_age),
    .slot_o (slot)
  );

  ehr_mem #(.DEPTH(DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (slot),
    .rdata_o (mem_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (func_e'(func_i))
            FN_PEEK, FN_DEL_AGE: state_d = age_bad ? ST_FIN : ST_RD;
            FN_DEL_MAT:          state_d = ST_RD;
            default:             state_d = ST_FIN;
          endcase
        end
      end
      ST_RD:    state_d = (cnt_q >= held_q) ? ST_FIN : ST_CK;
      ST_CK: begin
        case (op_q)
          FN_PEEK:    state_d = ST_FIN;
          FN_DEL_AGE: state_d = ST_SH_RD;
          default:    state_d = key_hit ? ST_SH_RD : ST_RD;
        endcase
      end
      ST_SH_RD: state_d = (cnt_q == '0) ? ST_FIN : ST_SH_WR;
      ST_SH_WR: state_d = ST_SH_RD;
      ST_FIN:   state_d = out_free ? ST_IDLE : ST_FIN;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_d        = op_q;
    wp_d        = wp_q;
    held_d      = held_q;
    cnt_d       = cnt_q;
    key_tgt_d   = key_tgt_q;
    key_kind_d  = key_kind_q;
    rec_d       = rec_q;
    ok_d        = ok_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rec_d   = out_rec_q;
    out_ok_d    = out_ok_q;
    out_fill_d  = out_fill_q;
    mem_we      = 1'b0;
    mem_waddr   = slot;
    mem_wdata   = mem_rdata;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          op_d       = func_e'(func_i);
          key_tgt_d  = target_i;
          key_kind_d = kind_i;
          cnt_d      = '0;
          rec_d      = '0;
          ok_d       = 1'b0;
          case (func_e'(func_i))
            FN_APPEND: begin
              if (amount_i != '0) begin
                mem_we    = 1'b1;
                mem_waddr = wp_q;
                mem_wdata = new_rec;
                rec_d     = new_rec;
                ok_d      = 1'b1;
                wp_d      = (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
                if (held_q != CW'(DEPTH)) begin
                  held_d = held_q + CW'(1);
                end
              end
            end
            FN_CLEAR: begin
              wp_d   = '0;
              held_d = '0;
            end
            FN_PEEK, FN_DEL_AGE: begin
              if (!age_bad) begin
                cnt_d = CW'(age_i);
              end
            end
            default: ;
          endcase
        end
      end
      ST_CK: begin
        case (op_q)
          FN_PEEK: begin
            rec_d = mem_rdata;
            ok_d  = 1'b1;
          end
          FN_DEL_AGE: rec_d = mem_rdata;
          default: begin
            if (key_hit) begin
              rec_d = mem_rdata;
            end else begin
              cnt_d = cnt_q + CW'(1);
            end
          end
        endcase
      end
      ST_SH_RD: begin
        // gap closed: step the write pointer and the fill count back
        if (cnt_q == '0) begin
          wp_d   = (wp_q == '0) ? PW'(DEPTH - 1) : wp_q - PW'(1);
          held_d = held_q - CW'(1);
          ok_d   = 1'b1;
        end
      end
      ST_SH_WR: begin
        // move the next newer record down one place
        mem_we = 1'b1;
        cnt_d  = cnt_q - CW'(1);
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rec_d   = rec_q;
          out_ok_d    = ok_q;
          out_fill_d  = 9'(held_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    cnt_q      <= cnt_d;
    key_tgt_q  <= key_tgt_d;
    key_kind_q <= key_kind_d;
    rec_q      <= rec_d;
    ok_q       <= ok_d;
    out_rec_q  <= out_rec_d;
    out_ok_q   <= out_ok_d;
    out_fill_q <= out_fill_d;
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = out_ok_q;
  assign rec_target_o = out_rec_q.target;
  assign rec_origin_o = out_rec_q.origin;
  assign rec_kind_o   = out_rec_q.kind;
  assign rec_amount_o = out_rec_q.amount;
  assign rec_stamp_o  = out_rec_q.stamp;
  assign fill_o       = out_fill_q;

endmodule

// ----- sv/ehr_slot.sv -----
module ehr_slot #(
  parameter int DEPTH = ehr_pkg::DEPTH_DEF
) (
  input  logic [$clog2(DEPTH)-1:0]   wp_i,
  input  logic [$clog2(DEPTH+1)-1:0] age_i,
  output logic [$clog2(DEPTH)-1:0]   slot_o
);
  import ehr_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW:0] sum;

  // slot = (wp + DEPTH - 1 - age) mod DEPTH, with one conditional subtract
  always_comb begin
    sum = (CW+1)'(wp_i) + (CW+1)'(DEPTH - 1) - (CW+1)'(age_i);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    slot_o = sum[PW-1:0];
  end

endmodule

// ----- sv/ehr_mem.sv -----
module ehr_mem #(
  parameter int DEPTH = ehr_pkg::DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  ehr_pkg::rec_t            wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output ehr_pkg::rec_t            rdata_o
);
  import ehr_pkg::*;

  rec_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- sv/ehr_checker.sv -----
`include "event_history_ring_core_defines.svh"

module ehr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        ok_o,
  input logic [7:0]  rec_target_o,
  input logic [7:0]  rec_origin_o,
  input logic [7:0]  rec_kind_o,
  input logic [15:0] rec_amount_o,
  input logic [31:0] rec_stamp_o
);

  // a stalled result stays offered
  `EHR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  // an accepted operation keeps the block busy in the next cycle
  `EHR_ASSERT_NEXT(a_busy_after_xfer, in_valid_i && !in_stall_o, in_stall_o)
  // a failed result carries an all-zero record
  `EHR_ASSERT_IMPL(a_fail_zero, out_valid_o && !ok_o,
                   rec_target_o == '0 && rec_origin_o == '0 && rec_kind_o == '0 &&
                   rec_amount_o == '0 && rec_stamp_o == '0)
  // only nonzero amounts are ever stored, so a successful result shows one
  `EHR_ASSERT_IMPL(a_ok_amount, out_valid_o && ok_o, rec_amount_o != '0)

endmodule

bind event_history_ring_core ehr_checker u_ehr_checker (.*);
